FILE: rtl/bre_pkg.sv
package bre_pkg;

  localparam int MAX_PORTS     = 4;
  localparam int ID_BITS       = 4;
  localparam int HOP_BITS      = 8;
  localparam int PORT_IDX_BITS = 2;
  localparam int PC_BITS       = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 4;

  typedef logic [ID_BITS-1:0]       id_t;
  typedef logic [HOP_BITS-1:0]      hop_t;
  typedef logic [PORT_IDX_BITS-1:0] port_idx_t;
  typedef logic [MAX_PORTS-1:0]     port_mask_t;
  typedef logic [PC_BITS-1:0]       port_cnt_t;
  typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

  localparam hop_t      HOP_MAX        = {HOP_BITS{1'b1}};
  localparam port_cnt_t PORT_COUNT_RST = PC_BITS'(MAX_PORTS);

  // Configuration register indexes.
  localparam cfg_idx_t CFG_OWN_ID     = 3'd0;
  localparam cfg_idx_t CFG_PORT_COUNT = 3'd1;
  localparam cfg_idx_t CFG_NEIGH_0    = 3'd2;
  localparam cfg_idx_t CFG_NEIGH_1    = 3'd3;
  localparam cfg_idx_t CFG_NEIGH_2    = 3'd4;
  localparam cfg_idx_t CFG_NEIGH_3    = 3'd5;

  typedef struct packed {
    id_t  root_id;
    id_t  sender_id;
    hop_t hops;
  } item_t;

  typedef struct packed {
    logic      found;
    port_idx_t port;
  } lookup_t;

  typedef struct packed {
    logic       do_forward;
    port_mask_t port_mask;
    id_t        root_id;
    hop_t       hops;
    logic       root_port_valid;
    port_idx_t  root_port_index;
  } result_t;

endpackage

FILE: rtl/bre_port_find.sv
module bre_port_find (
  input  bre_pkg::id_t                      sender_id,
  input  bre_pkg::id_t [bre_pkg::MAX_PORTS-1:0] neighbor_id,
  input  bre_pkg::port_mask_t               used_mask,
  output bre_pkg::lookup_t                  lookup
);
  import bre_pkg::*;

  // Scan from the top so that the lowest matching port wins.
  always_comb begin
    lookup = '0;
    for (int i = MAX_PORTS - 1; i >= 0; i--) begin
      if (used_mask[i] && (neighbor_id[i] == sender_id)) begin
        lookup.found = 1'b1;
        lookup.port  = PORT_IDX_BITS'(i);
      end
    end
  end

endmodule

FILE: rtl/bre_elect.sv
module bre_elect (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                restart,
  input  bre_pkg::id_t        restart_root,
  input  logic                update,
  input  bre_pkg::item_t      item,
  input  bre_pkg::lookup_t    lookup,
  input  bre_pkg::id_t        own_id,
  input  bre_pkg::port_mask_t used_mask,
  output bre_pkg::result_t    result
);
  import bre_pkg::*;

  id_t        root_r,    root_nxt;
  hop_t       hop_r,     hop_nxt;
  port_idx_t  rport_r,   rport_nxt;
  logic       rset_r,    rset_nxt;
  port_mask_t blocked_r, blocked_nxt;

  hop_t path;
  logic accept;
  logic block;
  logic forward;

  assign path = (item.hops == HOP_MAX) ? HOP_MAX : item.hops + hop_t'(1);

  always_comb begin
    root_nxt    = root_r;
    hop_nxt     = hop_r;
    rport_nxt   = rport_r;
    rset_nxt    = rset_r;
    blocked_nxt = blocked_r;
    accept      = 1'b0;
    block       = 1'b0;

    priority if (item.root_id < root_r) begin
      root_nxt = item.root_id;
      hop_nxt  = path;
      accept   = 1'b1;
    end else if (item.root_id == root_r) begin
      priority if (path < hop_r) begin
        hop_nxt = path;
        accept  = 1'b1;
      end else if (path == hop_r) begin
        accept = item.sender_id < own_id;
        block  = item.sender_id > own_id;
      end else begin
        block = 1'b1;
      end
    end else begin
      // A message naming a higher root is ignored.
      block = 1'b0;
    end

    // The root port is blocked too, so nothing goes back upstream.
    if (accept) begin
      rset_nxt = lookup.found;
      if (lookup.found) begin
        rport_nxt   = lookup.port;
        blocked_nxt = blocked_r | (port_mask_t'(1) << lookup.port);
      end
    end else if (block && lookup.found) begin
      blocked_nxt = blocked_r | (port_mask_t'(1) << lookup.port);
    end

    forward = accept && (root_nxt != own_id);
  end

  always_comb begin
    result.do_forward      = forward;
    result.port_mask       = forward ? (~blocked_nxt & used_mask) : '0;
    result.root_id         = root_nxt;
    result.hops            = hop_nxt;
    result.root_port_valid = rset_nxt;
    result.root_port_index = rset_nxt ? rport_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r    <= '0;
      hop_r     <= '0;
      rport_r   <= '0;
      rset_r    <= 1'b0;
      blocked_r <= '0;
    end else if (restart) begin
      root_r    <= restart_root;
      hop_r     <= '0;
      rport_r   <= '0;
      rset_r    <= 1'b0;
      blocked_r <= '0;
    end else if (update) begin
      root_r    <= root_nxt;
      hop_r     <= hop_nxt;
      rport_r   <= rport_nxt;
      rset_r    <= rset_nxt;
      blocked_r <= blocked_nxt;
    end
  end

endmodule

FILE: rtl/bridge_root_election_step.sv
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   msg_root_id, msg_sender_id, msg_hops
// out_      output     out_valid/out_stall do_forward, out_port_mask, out_root_id,
//                                          out_hops, root_port_valid, root_port_index
// cfg_      input      cfg_wr_en           cfg_index, cfg_data
//
// One item per cycle is sustained while the result side does not stall; an item
// moves from acceptance through the input register, then the result register.
// The election state is updated in the same cycle as the result is computed.
// Reset is synchronous, active low, and restores all but item and result data.
// A stall on the result side holds the result and then backs up the input.
module bridge_root_election_step (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  bre_pkg::id_t           in_msg_root_id,
  input  bre_pkg::id_t           in_msg_sender_id,
  input  bre_pkg::hop_t          in_msg_hops,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_do_forward,
  output bre_pkg::port_mask_t    out_out_port_mask,
  output bre_pkg::id_t           out_out_root_id,
  output bre_pkg::hop_t          out_out_hops,
  output logic                   out_root_port_valid,
  output bre_pkg::port_idx_t     out_root_port_index,
  input  logic                   cfg_wr_en,
  input  bre_pkg::cfg_idx_t      cfg_index,
  input  bre_pkg::cfg_data_t     cfg_data
);
  import bre_pkg::*;

  id_t                  own_id_r;
  port_cnt_t            port_count_r;
  id_t [MAX_PORTS-1:0]  neigh_r;

  logic     item_valid_r, item_valid_nxt;
  item_t    item_r;
  logic     res_valid_r;
  result_t  res_r;
  result_t  res_nxt;
  lookup_t  lookup;
  port_mask_t used_mask;
  logic     advance;
  logic     in_take;
  logic     restart;

  assign advance  = !res_valid_r || !out_stall;
  assign in_stall = item_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign restart  = cfg_wr_en && (cfg_index == CFG_OWN_ID);

  always_comb begin
    for (int i = 0; i < MAX_PORTS; i++) begin
      used_mask[i] = port_count_r > PC_BITS'(i);
    end
  end

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_take) begin
      item_valid_nxt = 1'b1;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r     <= '0;
      port_count_r <= PORT_COUNT_RST;
      neigh_r      <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OWN_ID:     own_id_r     <= cfg_data[ID_BITS-1:0];
        CFG_PORT_COUNT: port_count_r <= cfg_data[PC_BITS-1:0];
        CFG_NEIGH_0:    neigh_r[0]   <= cfg_data[ID_BITS-1:0];
        CFG_NEIGH_1:    neigh_r[1]   <= cfg_data[ID_BITS-1:0];
        CFG_NEIGH_2:    neigh_r[2]   <= cfg_data[ID_BITS-1:0];
        CFG_NEIGH_3:    neigh_r[3]   <= cfg_data[ID_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      if (advance) begin
        res_valid_r <= item_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.root_id   <= in_msg_root_id;
      item_r.sender_id <= in_msg_sender_id;
      item_r.hops      <= in_msg_hops;
    end
    if (advance && item_valid_r) begin
      res_r <= res_nxt;
    end
  end

  bre_port_find u_port_find (
    .sender_id   (item_r.sender_id),
    .neighbor_id (neigh_r),
    .used_mask   (used_mask),
    .lookup      (lookup)
  );

  bre_elect u_elect (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (restart),
    .restart_root (cfg_data[ID_BITS-1:0]),
    .update       (advance && item_valid_r),
    .item         (item_r),
    .lookup       (lookup),
    .own_id       (own_id_r),
    .used_mask    (used_mask),
    .result       (res_nxt)
  );

  assign out_valid           = res_valid_r;
  assign out_do_forward      = res_r.do_forward;
  assign out_out_port_mask   = res_r.port_mask;
  assign out_out_root_id     = res_r.root_id;
  assign out_out_hops        = res_r.hops;
  assign out_root_port_valid = res_r.root_port_valid;
  assign out_root_port_index = res_r.root_port_index;

endmodule

FILE: verif/bre_checker.sv
`timescale 1ns / 100ps

module bre_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  bre_pkg::id_t        in_msg_root_id,
  input  bre_pkg::id_t        in_msg_sender_id,
  input  bre_pkg::hop_t       in_msg_hops,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                out_do_forward,
  input  bre_pkg::port_mask_t out_out_port_mask,
  input  bre_pkg::id_t        out_out_root_id,
  input  bre_pkg::hop_t       out_out_hops,
  input  logic                out_root_port_valid,
  input  bre_pkg::port_idx_t  out_root_port_index,
  input  logic                cfg_wr_en,
  input  bre_pkg::cfg_idx_t   cfg_index,
  input  bre_pkg::cfg_data_t  cfg_data,
  output int                  fail_count,
  output int                  pending_count
);
  import bre_pkg::*;

  // Shadow of the configuration registers.
  id_t        own_id;
  port_cnt_t  port_count;
  id_t        neigh [MAX_PORTS];

  // Shadow of the election state.
  id_t        believed_root;
  hop_t       hop_dist;
  port_idx_t  root_port;
  logic       root_port_set;
  port_mask_t blocked;

  result_t    pending_results [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  function automatic void restart_election();
    believed_root = own_id;
    hop_dist      = '0;
    root_port     = '0;
    root_port_set = 1'b0;
    blocked       = '0;
  endfunction

  function automatic result_t elect(input item_t m);
    int         n;
    int         i;
    logic       found;
    port_idx_t  p;
    logic [8:0] path_w;
    hop_t       path;
    logic       take;
    logic       block;
    port_mask_t used;
    result_t    r;
    n = (int'(port_count) > MAX_PORTS) ? MAX_PORTS : int'(port_count);
    found = 1'b0;
    p = '0;
    // Scan downwards so that the lowest matching port wins.
    for (i = n - 1; i >= 0; i--) begin
      if (neigh[i] == m.sender_id) begin
        found = 1'b1;
        p = port_idx_t'(i);
      end
    end
    path_w = {1'b0, m.hops} + 9'd1;
    path = (path_w > {1'b0, HOP_MAX}) ? HOP_MAX : path_w[7:0];
    take = 1'b0;
    block = 1'b0;
    if (m.root_id < believed_root) begin
      believed_root = m.root_id;
      hop_dist = path;
      take = 1'b1;
    end else if (m.root_id == believed_root) begin
      if (path < hop_dist) begin
        hop_dist = path;
        take = 1'b1;
      end else if (path == hop_dist) begin
        if (m.sender_id < own_id) take = 1'b1;
        else if (m.sender_id > own_id) block = 1'b1;
      end else begin
        block = 1'b1;
      end
    end
    if (take) begin
      if (found) begin
        root_port = p;
        root_port_set = 1'b1;
        blocked[p] = 1'b1;
      end else begin
        root_port_set = 1'b0;
      end
    end else if (block && found) begin
      blocked[p] = 1'b1;
    end
    used = port_mask_t'((1 << n) - 1);
    r.do_forward      = take && (believed_root != own_id);
    r.port_mask       = r.do_forward ? (~blocked & used) : '0;
    r.root_id         = believed_root;
    r.hops            = hop_dist;
    r.root_port_valid = root_port_set;
    r.root_port_index = root_port_set ? root_port : '0;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    item_t   msg;
    if (!rst_n) begin
      own_id = '0;
      port_count = PORT_COUNT_RST;
      foreach (neigh[k]) neigh[k] = '0;
      restart_election();
      pending_results.delete();
    end else begin
      // Compare first, so that an item accepted at this edge cannot pair
      // with a result that leaves at the same edge.
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no item waiting, actual root %0h hops %0h",
                   $time, out_out_root_id, out_out_hops);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("do_forward", want.do_forward, out_do_forward);
          check_field("port_mask", want.port_mask, out_out_port_mask);
          check_field("root_id", want.root_id, out_out_root_id);
          check_field("hops", want.hops, out_out_hops);
          check_field("root_port_valid", want.root_port_valid, out_root_port_valid);
          check_field("root_port_index", want.root_port_index, out_root_port_index);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_OWN_ID: begin
            own_id = cfg_data;
            restart_election();
          end
          CFG_PORT_COUNT: port_count = port_cnt_t'(cfg_data);
          CFG_NEIGH_0:    neigh[0] = cfg_data;
          CFG_NEIGH_1:    neigh[1] = cfg_data;
          CFG_NEIGH_2:    neigh[2] = cfg_data;
          CFG_NEIGH_3:    neigh[3] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        msg.root_id   = in_msg_root_id;
        msg.sender_id = in_msg_sender_id;
        msg.hops      = in_msg_hops;
        pending_results.push_back(elect(msg));
      end
    end
    pending_count = pending_results.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bre_pkg::*;

  // Indexes beyond the last register; writes to them must be ignored.
  localparam cfg_idx_t CFG_SPARE_6 = 3'd6;
  localparam cfg_idx_t CFG_SPARE_7 = 3'd7;

  localparam int BLOCKS     = 21;
  localparam int BLOCK_MSGS = 50;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  id_t        in_msg_root_id;
  id_t        in_msg_sender_id;
  hop_t       in_msg_hops;
  logic       out_valid;
  logic       out_stall;
  logic       out_do_forward;
  port_mask_t out_out_port_mask;
  id_t        out_out_root_id;
  hop_t       out_out_hops;
  logic       out_root_port_valid;
  port_idx_t  out_root_port_index;
  logic       cfg_wr_en;
  cfg_idx_t   cfg_index;
  cfg_data_t  cfg_data;

  int         fail_count;
  int         pending_count;
  int         idle_pct;
  int         stall_pct;
  id_t        cur_own;
  id_t        cur_neigh [MAX_PORTS];

  bridge_root_election_step dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_msg_root_id      (in_msg_root_id),
    .in_msg_sender_id    (in_msg_sender_id),
    .in_msg_hops         (in_msg_hops),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_do_forward      (out_do_forward),
    .out_out_port_mask   (out_out_port_mask),
    .out_out_root_id     (out_out_root_id),
    .out_out_hops        (out_out_hops),
    .out_root_port_valid (out_root_port_valid),
    .out_root_port_index (out_root_port_index),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  bre_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_msg_root_id      (in_msg_root_id),
    .in_msg_sender_id    (in_msg_sender_id),
    .in_msg_hops         (in_msg_hops),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_do_forward      (out_do_forward),
    .out_out_port_mask   (out_out_port_mask),
    .out_out_root_id     (out_out_root_id),
    .out_out_hops        (out_out_hops),
    .out_root_port_valid (out_root_port_valid),
    .out_root_port_index (out_root_port_index),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .pending_count       (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // The receiver stalls at random according to the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == CFG_OWN_ID) cur_own = data;
    else if (idx >= CFG_NEIGH_0 && idx <= CFG_NEIGH_3) cur_neigh[idx - CFG_NEIGH_0] = data;
  endtask

  task automatic send_msg(input id_t root, input id_t sender, input hop_t hops);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_msg_root_id   = root;
    in_msg_sender_id = sender;
    in_msg_hops      = hops;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Waits until every result is out; the block is then idle.
  task automatic settle();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    id_t  root_base;
    hop_t hop_base;
    id_t  r_root;
    id_t  r_sender;
    hop_t r_hops;
    int   pick;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_msg_root_id   = '0;
    in_msg_sender_id = '0;
    in_msg_hops      = '0;
    out_stall        = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    idle_pct         = 0;
    stall_pct        = 0;
    cur_own          = '0;
    foreach (cur_neigh[k]) cur_neigh[k] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part: one path through every election rule.
    write_reg(CFG_OWN_ID, 4'd6);
    write_reg(CFG_PORT_COUNT, 4'd3);
    write_reg(CFG_NEIGH_0, 4'd2);
    write_reg(CFG_NEIGH_1, 4'd9);
    write_reg(CFG_NEIGH_2, 4'd4);
    write_reg(CFG_NEIGH_3, 4'd9);
    send_msg(4'd15, 4'd15, 8'd255);  // higher root, ignored
    send_msg(4'd6, 4'd1, 8'd0);      // longer path, unknown sender
    send_msg(4'd6, 4'd9, 8'd0);      // longer path, blocks port 1
    send_msg(4'd3, 4'd2, 8'd4);      // lower root adopted
    send_msg(4'd3, 4'd4, 8'd4);      // equal path, lower sender accepted
    send_msg(4'd3, 4'd7, 8'd4);      // equal path, higher sender blocks
    send_msg(4'd3, 4'd6, 8'd4);      // equal path, sender is this bridge
    send_msg(4'd3, 4'd9, 8'd2);      // shorter path accepted
    send_msg(4'd3, 4'd5, 8'd9);      // longer path blocks
    send_msg(4'd3, 4'd0, 8'd1);      // shorter path from an unknown sender
    send_msg(4'd0, 4'd15, 8'd254);   // lower root, path reaches the ceiling
    send_msg(4'd0, 4'd15, 8'd255);   // path saturates, higher sender blocks
    send_msg(4'd0, 4'd0, 8'd255);    // saturated equal path, lower sender
    settle();
    write_reg(CFG_OWN_ID, 4'd0);
    send_msg(4'd0, 4'd2, 8'd0);
    send_msg(4'd0, 4'd9, 8'd255);
    settle();
    // No ports in use at all.
    write_reg(CFG_PORT_COUNT, 4'd0);
    write_reg(CFG_OWN_ID, 4'd15);
    send_msg(4'd1, 4'd2, 8'd3);
    send_msg(4'd1, 4'd9, 8'd0);
    settle();
    // Port count above the port number, duplicate neighbour ids.
    write_reg(CFG_PORT_COUNT, 4'd7);
    write_reg(CFG_NEIGH_0, 4'd0);
    write_reg(CFG_NEIGH_2, 4'd15);
    write_reg(CFG_SPARE_6, 4'd15);
    write_reg(CFG_SPARE_7, 4'd15);
    write_reg(CFG_OWN_ID, 4'd15);
    send_msg(4'd0, 4'd9, 8'd0);
    send_msg(4'd0, 4'd15, 8'd0);
    send_msg(4'd0, 4'd0, 8'd0);
    send_msg(4'd0, 4'd15, 8'd1);
    settle();

    // Random part: each block restarts the election with a fresh setting and
    // keeps roots and hop counts close together, so that ties are frequent.
    for (int blk = 0; blk < BLOCKS; blk++) begin
      case (blk % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      settle();
      write_reg(CFG_PORT_COUNT, ($urandom_range(3) == 0) ? cfg_data_t'($urandom_range(7))
                                                          : cfg_data_t'($urandom_range(1, 4)));
      write_reg(CFG_NEIGH_0, cfg_data_t'($urandom_range(15)));
      write_reg(CFG_NEIGH_1, cfg_data_t'($urandom_range(15)));
      write_reg(CFG_NEIGH_2, cfg_data_t'($urandom_range(15)));
      write_reg(CFG_NEIGH_3, cfg_data_t'($urandom_range(15)));
      write_reg(CFG_OWN_ID, cfg_data_t'($urandom_range(15)));
      root_base = id_t'($urandom_range(13));
      hop_base  = ($urandom_range(4) == 0) ? hop_t'($urandom_range(250, 253))
                                           : hop_t'($urandom_range(6));
      for (int n = 0; n < BLOCK_MSGS; n++) begin
        if ($urandom_range(99) < 80) begin
          r_root = root_base + id_t'($urandom_range(2));
          r_hops = hop_base + hop_t'($urandom_range(2));
          pick   = $urandom_range(99);
          if (pick < 70)      r_sender = cur_neigh[$urandom_range(MAX_PORTS - 1)];
          else if (pick < 82) r_sender = cur_own;
          else                r_sender = id_t'($urandom_range(15));
        end else begin
          r_root   = id_t'($urandom_range(15));
          r_sender = id_t'($urandom_range(15));
          r_hops   = hop_t'($urandom_range(255));
        end
        send_msg(r_root, r_sender, r_hops);
      end
    end

    settle();
    repeat (5) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
